### rtl/accel_tilt_angles_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tilt angle core
// Shared wrappers for concurrent checks, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_CORE_DEFINES_SVH
`define ACCEL_TILT_ANGLES_CORE_DEFINES_SVH

// Check that holds outside reset.
`define ATA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also covers the reset cycles.
`define ATA_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg
// Types, constants and the arctangent table of the tilt angle core.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int DefIterations = 16;
  localparam int SqrtSteps     = 32;   // one root bit per cell
  localparam int CoordWidth    = 36;
  localparam int AngleWidth    = 25;   // signed Q16 degrees

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [AngleWidth-1:0] angle_t;

  // Partial square root: remaining radicand and root bits found so far.
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sqrt_t;

  // Vectoring state of one angle.
  typedef struct packed {
    coord_t cx;
    coord_t cy;
    angle_t acc;
    logic   zden;   // denominator was zero, cells leave the item alone
  } cordic_t;

  // atan(2^-i) in degrees, Q16, rounded to nearest.
  function automatic angle_t atan_q16(input logic [4:0] idx);
    angle_t v;
    case (idx)
      5'd0:    v = 25'sd2949120;
      5'd1:    v = 25'sd1740967;
      5'd2:    v = 25'sd919879;
      5'd3:    v = 25'sd466945;
      5'd4:    v = 25'sd234379;
      5'd5:    v = 25'sd117304;
      5'd6:    v = 25'sd58666;
      5'd7:    v = 25'sd29335;
      5'd8:    v = 25'sd14668;
      5'd9:    v = 25'sd7334;
      5'd10:   v = 25'sd3667;
      5'd11:   v = 25'sd1833;
      5'd12:   v = 25'sd917;
      5'd13:   v = 25'sd458;
      5'd14:   v = 25'sd229;
      5'd15:   v = 25'sd115;
      5'd16:   v = 25'sd57;
      5'd17:   v = 25'sd29;
      5'd18:   v = 25'sd14;
      5'd19:   v = 25'sd7;
      5'd20:   v = 25'sd4;
      5'd21:   v = 25'sd2;
      5'd22:   v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Whole degrees truncated toward zero and clamped to +-90; a zero
  // denominator gives +-90 by the numerator sign, or 0 for zero over zero.
  function automatic logic signed [7:0] angle_deg(input cordic_t c);
    angle_t           mag;
    logic [8:0]       q;
    logic [7:0]       qc;
    logic signed [7:0] r;
    mag = c.acc[AngleWidth-1] ? -c.acc : c.acc;
    q   = mag[AngleWidth-1:16];
    qc  = (q > 9'd90) ? 8'd90 : q[7:0];
    r   = c.acc[AngleWidth-1] ? -$signed(qc) : $signed(qc);
    if (c.zden) begin
      if (c.cy == '0) begin
        r = 8'sd0;
      end else if (c.cy[CoordWidth-1]) begin
        r = -8'sd90;
      end else begin
        r = 8'sd90;
      end
    end
    return r;
  endfunction

endpackage

### rtl/ata_sample_if.sv
// ----------------------------------------------------------------------------
// ata_sample_if / ata_angles_if
// Valid/ready channels for accelerometer samples and tilt angle results.
// ----------------------------------------------------------------------------
interface ata_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;

  modport source (output valid, acc_x, acc_y, acc_z, input ready);
  modport sink   (input valid, acc_x, acc_y, acc_z, output ready);
endinterface

interface ata_angles_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] pitch_deg;
  logic signed [7:0] roll_deg;
  logic signed [7:0] incline_deg;

  modport source (output valid, pitch_deg, roll_deg, incline_deg, input ready);
  modport sink   (input valid, pitch_deg, roll_deg, incline_deg, output ready);
endinterface

### rtl/ata_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ata_sqrt_cell
// One restoring square root step: decides root bit Bit and registers it.
// ----------------------------------------------------------------------------
module ata_sqrt_cell #(
  parameter int Bit = 31
) (
  input  logic           clk,
  input  logic           en,
  input  ata_pkg::sqrt_t d,
  output ata_pkg::sqrt_t q
);

  logic [63:0]    trial;
  ata_pkg::sqrt_t nxt;

  // (2*root + 2^Bit) * 2^Bit; the root has no bits at or below Bit yet.
  assign trial = (64'(d.root) << (Bit + 1)) | (64'd1 << (2 * Bit));

  always_comb begin
    nxt = d;
    if (d.rem >= trial) begin
      nxt.rem  = d.rem - trial;
      nxt.root = d.root | (32'd1 << Bit);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

### rtl/ata_cordic_cell.sv
// ----------------------------------------------------------------------------
// ata_cordic_cell
// One CORDIC vectoring rotation by atan(2^-Step), registered.
// ----------------------------------------------------------------------------
module ata_cordic_cell #(
  parameter int Step = 0
) (
  input  logic             clk,
  input  logic             en,
  input  ata_pkg::cordic_t d,
  output ata_pkg::cordic_t q
);

  ata_pkg::coord_t  dx;
  ata_pkg::coord_t  dy;
  ata_pkg::angle_t  da;
  ata_pkg::cordic_t nxt;

  assign dx = d.cy >>> Step;
  assign dy = d.cx >>> Step;
  assign da = ata_pkg::atan_q16(5'(Step));

  // Once y reaches zero the rotation stops for good.
  always_comb begin
    nxt = d;
    if (!d.zden && d.cy != '0) begin
      if (!d.cy[ata_pkg::CoordWidth-1]) begin
        nxt.cx  = d.cx + dx;
        nxt.cy  = d.cy - dy;
        nxt.acc = d.acc + da;
      end else begin
        nxt.cx  = d.cx - dx;
        nxt.cy  = d.cy + dy;
        nxt.acc = d.acc - da;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end

endmodule

### rtl/accel_tilt_angles_core.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_core
// Pitch, roll and incline in whole degrees from one three-axis sample.
// ----------------------------------------------------------------------------
// The core takes one signed 16-bit accelerometer sample per clock and returns
// pitch, roll and incline angles in whole degrees, truncated toward zero and
// limited to -90..90. It is a fully pipelined chain of cells: two stages form
// squares and sums, 32 square root stages each settle one bit of the three
// magnitudes, and CORDIC_ITERATIONS vectoring stages each apply one rotation to
// the three angles, followed by the output register. A new sample is taken on
// every cycle unless the pipeline holds. The pipeline holds only when a
// finished result sits in the output register, is not taken, and the last
// pipeline stage carries another one; while it holds, every stage holds with
// it, empty ones included, and the sample input is not ready.
// The core keeps no state between samples.
// ----------------------------------------------------------------------------
module accel_tilt_angles_core #(
  parameter int CORDIC_ITERATIONS = ata_pkg::DefIterations
) (
  input  logic                clk,
  input  logic                rst,
  ata_sample_if.sink          sample,
  ata_angles_if.source        angles
);

  localparam int SqN   = ata_pkg::SqrtSteps;
  localparam int Depth = 2 + SqN + CORDIC_ITERATIONS;

  // Occupancy of every pipeline stage; the whole row moves together.
  logic [Depth-1:0] vld;
  logic             adv;

  assign adv          = !(vld[Depth-1] && angles.valid && !angles.ready);
  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], sample.valid};
    end
  end

  // Stage one: squares of the three axes.
  logic signed [15:0] x1, y1, z1;
  logic [31:0]        xx, yy, zz;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1 <= sample.acc_x;
      y1 <= sample.acc_y;
      z1 <= sample.acc_z;
      xx <= 32'(sample.acc_x * sample.acc_x);
      yy <= 32'(sample.acc_y * sample.acc_y);
      zz <= 32'(sample.acc_z * sample.acc_z);
    end
  end

  // Stage two: the three sums of squares, each below 2^31 + 1.
  logic signed [15:0] x2, y2, z2;
  logic [31:0]        s_yz, s_xz, s_xy;

  always_ff @(posedge clk) begin
    if (adv) begin
      x2   <= x1;
      y2   <= y1;
      z2   <= z1;
      s_yz <= yy + zz;
      s_xz <= xx + zz;
      s_xy <= xx + yy;
    end
  end

  // Square root row. Lane 0 is the y-z magnitude for pitch, lane 1 the x-z
  // magnitude for roll, lane 2 the x-y magnitude for incline. The radicand is
  // the sum shifted up by 32, so each root is Q16.
  ata_pkg::sqrt_t     sq [0:SqN][0:2];
  logic signed [15:0] sx [0:SqN];
  logic signed [15:0] sy [0:SqN];
  logic signed [15:0] sz [0:SqN];

  assign sq[0][0] = '{rem: {s_yz, 32'd0}, root: 32'd0};
  assign sq[0][1] = '{rem: {s_xz, 32'd0}, root: 32'd0};
  assign sq[0][2] = '{rem: {s_xy, 32'd0}, root: 32'd0};
  assign sx[0]    = x2;
  assign sy[0]    = y2;
  assign sz[0]    = z2;

  for (genvar j = 0; j < SqN; j++) begin : g_sqrt
    for (genvar l = 0; l < 3; l++) begin : g_lane
      ata_sqrt_cell #(.Bit(SqN - 1 - j)) u_cell (
        .clk (clk),
        .en  (adv),
        .d   (sq[j][l]),
        .q   (sq[j+1][l])
      );
    end
    // The raw axes ride along: x and y for the pitch and roll numerators, z for the incline denominator and its sign.
    always_ff @(posedge clk) begin
      if (adv) begin
        sx[j+1] <= sx[j];
        sy[j+1] <= sy[j];
        sz[j+1] <= sz[j];
      end
    end
  end

  // CORDIC row. Pitch and roll rotate (magnitude, axis << 16); incline rotates
  // (|z| << 16, magnitude) and is negated at the end when z is negative.
  ata_pkg::cordic_t   cd [0:CORDIC_ITERATIONS][0:2];
  logic               zn [0:CORDIC_ITERATIONS];
  logic [31:0]        m_yz, m_xz, m_xy;
  logic [16:0]        az;

  assign m_yz = sq[SqN][0].root;
  assign m_xz = sq[SqN][1].root;
  assign m_xy = sq[SqN][2].root;
  assign az   = sz[SqN][15] ? 17'(-$signed({sz[SqN][15], sz[SqN]}))
                            : {1'b0, sz[SqN]};

  assign cd[0][0] = '{cx: {4'd0, m_yz},
                      cy: {{4{sx[SqN][15]}}, sx[SqN], 16'd0},
                      acc: '0, zden: (m_yz == 32'd0)};
  assign cd[0][1] = '{cx: {4'd0, m_xz},
                      cy: {{4{sy[SqN][15]}}, sy[SqN], 16'd0},
                      acc: '0, zden: (m_xz == 32'd0)};
  assign cd[0][2] = '{cx: {3'd0, az, 16'd0},
                      cy: {4'd0, m_xy},
                      acc: '0, zden: (az == 17'd0)};
  assign zn[0]    = sz[SqN][15];

  for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cordic
    for (genvar l = 0; l < 3; l++) begin : g_lane
      ata_cordic_cell #(.Step(i)) u_cell (
        .clk (clk),
        .en  (adv),
        .d   (cd[i][l]),
        .q   (cd[i+1][l])
      );
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        zn[i+1] <= zn[i];
      end
    end
  end

  // Output register: loads the last stage on a move, empties on a transfer.
  logic signed [7:0] incl;

  assign incl = ata_pkg::angle_deg(cd[CORDIC_ITERATIONS][2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      angles.valid <= 1'b0;
    end else if (adv && vld[Depth-1]) begin
      angles.valid <= 1'b1;
    end else if (angles.ready) begin
      angles.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vld[Depth-1]) begin
      angles.pitch_deg   <= ata_pkg::angle_deg(cd[CORDIC_ITERATIONS][0]);
      angles.roll_deg    <= ata_pkg::angle_deg(cd[CORDIC_ITERATIONS][1]);
      angles.incline_deg <= zn[CORDIC_ITERATIONS] ? -incl : incl;
    end
  end

endmodule

### rtl/ata_checker.sv
// ----------------------------------------------------------------------------
// ata_checker
// Port-level checks of the tilt angle core, bound to the top level.
// ----------------------------------------------------------------------------
`include "accel_tilt_angles_core_defines.svh"

module ata_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] pitch_deg,
  input logic signed [7:0] roll_deg,
  input logic signed [7:0] incline_deg
);

  `ATA_CHECK_RST(a_rst_empty, $past(rst) |-> !out_valid, "result valid right after reset")
  `ATA_CHECK(a_hold, out_valid && !out_ready |=> out_valid, "result dropped before transfer")
  `ATA_CHECK(a_pitch_rng, out_valid |-> pitch_deg <= 8'sd90 && pitch_deg >= -8'sd90, "pitch range")
  `ATA_CHECK(a_roll_rng, out_valid |-> roll_deg <= 8'sd90 && roll_deg >= -8'sd90, "roll range")
  `ATA_CHECK(a_incl_rng, out_valid |-> incline_deg <= 8'sd90 && incline_deg >= -8'sd90, "incline range")

endmodule

bind accel_tilt_angles_core ata_checker u_ata_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (angles.valid),
  .out_ready   (angles.ready),
  .pitch_deg   (angles.pitch_deg),
  .roll_deg    (angles.roll_deg),
  .incline_deg (angles.incline_deg)
);

### dv/tb_accel_tilt_angles_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tilt angle core testbench
// Streams accelerometer samples into the core, computes the expected pitch,
// roll and incline for every sample that transfers, and compares each
// result that transfers out against the oldest expected one, field by field.
// ----------------------------------------------------------------------------

// The scoreboard holds its own model of the datapath: an exact integer square
// root for the magnitudes and a 16-step CORDIC vectoring loop for the angles.
class tilt_scoreboard;

  typedef struct {
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [7:0]  pitch_deg;
    logic signed [7:0]  roll_deg;
    logic signed [7:0]  incline_deg;
  } tilt_angles_t;

  localparam int Steps = 16;

  tilt_angles_t pending_angles[$];
  int           mismatches;

  function new();
    pending_angles = {};
    mismatches     = 0;
  endfunction

  // atan(2^-i) in degrees with 16 fractional bits, rounded to nearest.
  static function longint atan_step(int i);
    longint tbl[16];
    tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115};
    return tbl[i];
  endfunction

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Magnitude of (a, b) with 16 fractional bits.
  static function longint magnitude(longint a, longint b);
    longint unsigned sum;
    sum = longint'(a * a) + longint'(b * b);
    return longint'(int_sqrt(sum << 32));
  endfunction

  // Angle of (den, num) with den >= 0, whole degrees truncated toward zero.
  static function int vector_deg(longint num, longint den);
    longint cx;
    longint cy;
    longint acc;
    longint dx;
    longint dy;
    longint q;
    cx  = den;
    cy  = num;
    acc = 0;
    if (den == 0) return (num > 0) ? 90 : ((num < 0) ? -90 : 0);
    for (int i = 0; i < Steps; i++) begin
      if (cy == 0) break;
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        acc = acc + atan_step(i);
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        acc = acc - atan_step(i);
      end
    end
    q = acc / 65536;
    if (q > 90) q = 90;
    if (q < -90) q = -90;
    return int'(q);
  endfunction

  function void note_sample(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    tilt_angles_t e;
    longint       lx;
    longint       ly;
    longint       lz;
    int           incl;
    lx = x;
    ly = y;
    lz = z;
    e.acc_x     = x;
    e.acc_y     = y;
    e.acc_z     = z;
    e.pitch_deg = 8'(vector_deg(lx * 65536, magnitude(ly, lz)));
    e.roll_deg  = 8'(vector_deg(ly * 65536, magnitude(lx, lz)));
    incl        = vector_deg(magnitude(lx, ly), ((lz < 0) ? -lz : lz) * 65536);
    e.incline_deg = 8'((lz < 0) ? -incl : incl);
    pending_angles.push_back(e);
  endfunction

  function void check_result(logic signed [7:0] pitch, logic signed [7:0] roll,
                             logic signed [7:0] incline);
    tilt_angles_t e;
    if (pending_angles.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Result with nothing pending: pitch %0d roll %0d incline %0d",
                 pitch, roll, incline);
      end
      return;
    end
    e = pending_angles.pop_front();
    if (pitch !== e.pitch_deg || roll !== e.roll_deg || incline !== e.incline_deg) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Angle mismatch for x %0d y %0d z %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                 e.acc_x, e.acc_y, e.acc_z, e.pitch_deg, e.roll_deg, e.incline_deg,
                 pitch, roll, incline);
      end
    end
  endfunction

endclass

module tb_accel_tilt_angles_core;

  // Latency sizes the final wait after the drain at the end of the run.
  localparam int Latency    = 51;
  localparam int NumRandom  = 1200;
  localparam int CycleLimit = 400000;

  logic clk;
  logic rst;
  int   cycle_count;

  ata_sample_if sample_ch ();
  ata_angles_if angles_ch ();

  tilt_scoreboard tilt_sb;

  accel_tilt_angles_core u_top (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch.sink),
    .angles (angles_ch.source)
  );

  always #2 clk = ~clk;

  // Every transfer is seen here at the rising edge, before any nonblocking
  // update of that edge lands, so sampled values are the ones the core saw.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) begin
        tilt_sb.note_sample(sample_ch.acc_x, sample_ch.acc_y, sample_ch.acc_z);
      end
      if (angles_ch.valid && angles_ch.ready) begin
        tilt_sb.check_result(angles_ch.pitch_deg, angles_ch.roll_deg,
                             angles_ch.incline_deg);
      end
    end
  end

  // Guard against a hung pipeline: a generous limit on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver switches at random among stall patterns: always ready, random
  // stalls, long stalls, and a regular on/off rhythm, so that back-pressure
  // lands on every pipeline phase.
  int stall_mode;
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      angles_ch.ready <= 1'b0;
      stall_mode      <= 0;
      stall_left      <= 300;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(50, 400);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: begin
          angles_ch.ready <= 1'b1;
        end
        1: begin
          angles_ch.ready <= ($urandom_range(0, 99) < 60);
        end
        2: begin
          angles_ch.ready <= ($urandom_range(0, 99) < 15);
        end
        default: begin
          angles_ch.ready <= cycle_count[2];
        end
      endcase
    end
  end

  // Burst bookkeeping for the sender: how many transfers remain in the
  // current burst before a random gap is inserted.
  int burst_left;

  // Present one sample and hold it until it transfers. Valid stays high into
  // the next sample when no gap follows, so it is never dropped and raised in
  // the same time step.
  task automatic send_sample(input logic signed [15:0] x, input logic signed [15:0] y,
                             input logic signed [15:0] z);
    int gap;
    sample_ch.valid <= 1'b1;
    sample_ch.acc_x <= x;
    sample_ch.acc_y <= y;
    sample_ch.acc_z <= z;
    do @(posedge clk); while (!sample_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Occasionally a long stretch with no idling at all.
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(0, 30);
      gap = $urandom_range(1, 12);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every expected result has come back.
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (tilt_sb.pending_angles.size() != 0) @(posedge clk);
  endtask

  // A raw sample value drawn from one of several shapes: full range, small
  // values near the origin, the extremes, or zero.
  function automatic logic signed [15:0] pick_axis();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 16'($urandom());
    if (k < 7) return 16'($signed($urandom_range(0, 600)) - 300);
    if (k == 7) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
    if (k == 8) return 16'sd0;
    return 16'($signed($urandom_range(0, 40)) - 20);
  endfunction

  initial begin
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    int                 shape;
    tilt_sb         = new();
    clk             = 1'b0;
    rst             = 1'b1;
    cycle_count     = 0;
    burst_left      = 0;
    sample_ch.valid = 1'b0;
    sample_ch.acc_x = '0;
    sample_ch.acc_y = '0;
    sample_ch.acc_z = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed samples: zero over zero, zero z with a nonzero numerator,
    // negative z, exact 0 and 45 degree alignments, and field extremes.
    send_sample(16'sd0, 16'sd0, 16'sd0);
    send_sample(16'sd100, 16'sd0, 16'sd0);
    send_sample(-16'sd100, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd200, 16'sd0);
    send_sample(16'sd0, -16'sd200, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sd1000);
    send_sample(16'sd0, 16'sd0, -16'sd1000);
    send_sample(16'sd500, 16'sd0, 16'sd500);
    send_sample(-16'sd500, 16'sd0, -16'sd500);
    send_sample(16'sd0, 16'sd700, 16'sd700);
    send_sample(16'sd300, 16'sd300, -16'sd424);
    send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff, 16'sh8000);
    send_sample(16'sh7fff, 16'sh8000, 16'sd0);
    send_sample(16'sh8000, 16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd0, 16'sh8000);
    send_sample(16'sd1, 16'sd1, 16'sd1);
    send_sample(-16'sd1, 16'sd0, 16'sd1);
    send_sample(16'sd1, 16'sd0, 16'sh7fff);
    send_sample(16'sh7fff, 16'sd0, 16'sd1);
    send_sample(16'sd16384, -16'sd16384, 16'sd0);

    // The pipeline is allowed to run completely empty here.
    drain_results();

    for (int n = 0; n < NumRandom; n++) begin
      shape = $urandom_range(0, 9);
      rx = pick_axis();
      ry = pick_axis();
      rz = pick_axis();
      // Some samples lie on an exact diagonal between two axes.
      if (shape == 0) ry = rx;
      if (shape == 1) rz = -rx;
      if (n == NumRandom / 2) drain_results();
      send_sample(rx, ry, rz);
    end

    sample_ch.valid <= 1'b0;
    while (tilt_sb.pending_angles.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);

    if (tilt_sb.mismatches == 0 && tilt_sb.pending_angles.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/ata_pkg.sv
rtl/ata_sample_if.sv
rtl/ata_sqrt_cell.sv
rtl/ata_cordic_cell.sv
rtl/accel_tilt_angles_core.sv
rtl/ata_checker.sv
dv/tb_accel_tilt_angles_core.sv
